// File: sv/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types and constants for the request-line classifier: character
// codes, verb and extension tables, result field widths and the result type.
// ----------------------------------------------------------------------------
package hrlc_pkg;

    localparam int HEADER_BYTES_DEFAULT = 4096;

    // result field widths
    localparam int METHOD_W = 2;
    localparam int CTYPE_W  = 3;
    localparam int START_W  = 12;
    localparam int LEN_W    = 13;

    localparam logic [START_W-1:0] START_MAX = '1;
    localparam logic [LEN_W-1:0]   LEN_MAX   = '1;

    // verb classes
    localparam logic [METHOD_W-1:0] METHOD_GET   = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_HEAD  = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_OTHER = 2'd2;

    // content-type codes
    localparam logic [CTYPE_W-1:0] CT_HTML  = 3'd0;
    localparam logic [CTYPE_W-1:0] CT_JS    = 3'd1;
    localparam logic [CTYPE_W-1:0] CT_CSS   = 3'd2;
    localparam logic [CTYPE_W-1:0] CT_PNG   = 3'd3;
    localparam logic [CTYPE_W-1:0] CT_JPEG  = 3'd4;
    localparam logic [CTYPE_W-1:0] CT_PLAIN = 3'd5;
    localparam logic [CTYPE_W-1:0] CT_PDF   = 3'd6;

    // characters
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_SLASH = 8'h2F;

    // four-character words, index 0 holds the first character
    typedef logic [3:0][7:0] t_word4;

    localparam t_word4 VERB_GET  = {8'h00, "T", "E", "G"};
    localparam t_word4 VERB_HEAD = {"D", "A", "E", "H"};

    localparam int EXT_ENTRIES = 9;

    typedef struct packed {
        t_word4               text;
        logic [2:0]           len;
        logic [CTYPE_W-1:0]   code;
    } t_ext_entry;

    // match order matters: first hit wins
    localparam t_ext_entry EXT_TABLE [EXT_ENTRIES] = '{
        '{text: {"l", "m", "t", "h"},     len: 3'd4, code: CT_HTML},
        '{text: {8'h00, 8'h00, "s", "j"}, len: 3'd2, code: CT_JS},
        '{text: {8'h00, "s", "s", "c"},   len: 3'd3, code: CT_CSS},
        '{text: {8'h00, "g", "n", "p"},   len: 3'd3, code: CT_PNG},
        '{text: {8'h00, "g", "p", "j"},   len: 3'd3, code: CT_JPEG},
        '{text: {"g", "e", "p", "j"},     len: 3'd4, code: CT_JPEG},
        '{text: {8'h00, "t", "x", "t"},   len: 3'd3, code: CT_PLAIN},
        '{text: {8'h00, 8'h00, "d", "m"}, len: 3'd2, code: CT_PLAIN},
        '{text: {8'h00, "f", "d", "p"},   len: 3'd3, code: CT_PDF}
    };

    typedef enum logic [1:0] {
        PH_WAIT_VERB,
        PH_IN_VERB,
        PH_WAIT_PATH,
        PH_IN_PATH
    } t_phase;

    typedef enum logic [1:0] {
        DS_BEFORE,
        DS_BASE,
        DS_DOTS,
        DS_EXT
    } t_dot;

    typedef struct packed {
        logic [METHOD_W-1:0] method;
        logic                path_found;
        logic                path_is_root;
        logic                ext_found;
        logic [CTYPE_W-1:0]  media_kind;
        logic [START_W-1:0]  path_start;
        logic [LEN_W-1:0]    path_length;
        logic                header_too_long;
    } t_result;

    // Prefix match of the captured extension against the table.
    function automatic logic [CTYPE_W-1:0] match_ext(t_word4 bytes, logic [2:0] ext_len);
        logic [CTYPE_W-1:0] code;
        logic               ok;
        code = CT_HTML;
        for (int i = EXT_ENTRIES - 1; i >= 0; i--) begin
            ok = (ext_len >= EXT_TABLE[i].len);
            for (int k = 0; k < 4; k++) begin
                if ((3'(k) < EXT_TABLE[i].len) && (bytes[k] != EXT_TABLE[i].text[k])) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                code = EXT_TABLE[i].code;
            end
        end
        return code;
    endfunction

endpackage

// File: sv/hrlc_parser.sv
// ----------------------------------------------------------------------------
// hrlc_parser
// Per-byte parse state of the first request line and the result that the
// state gives, including the byte being stepped in.
// ----------------------------------------------------------------------------
module hrlc_parser #(
    parameter int HEADER_BYTES = hrlc_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output hrlc_pkg::t_result o_result
);
    import hrlc_pkg::*;

    localparam int POS_W = $clog2(HEADER_BYTES + 1);
    localparam int OFF_W = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(HEADER_BYTES);

    logic [POS_W-1:0] r_pos,       n_pos;
    t_phase           r_phase,     n_phase;
    logic [1:0]       r_vmatch,    n_vmatch;   // [0] GET, [1] HEAD
    logic [2:0]       r_vlen,      n_vlen;
    logic [OFF_W-1:0] r_off,       n_off;
    logic [POS_W-1:0] r_pcount,    n_pcount;
    t_dot             r_dot,       n_dot;
    t_word4           r_ext,       n_ext;
    logic [2:0]       r_ext_len,   n_ext_len;
    logic             r_done,      n_done;
    logic             r_ext_shut,  n_ext_shut;
    logic             r_slash,     n_slash;
    logic             r_too_long,  n_too_long;

    logic [31:0]      w_off_ext;
    logic [31:0]      w_cnt_ext;

    // next state
    always_comb begin
        logic path_step;
        logic ext_step;
        logic line_end;

        n_pos      = r_pos;
        n_phase    = r_phase;
        n_vmatch   = r_vmatch;
        n_vlen     = r_vlen;
        n_off      = r_off;
        n_pcount   = r_pcount;
        n_dot      = r_dot;
        n_ext      = r_ext;
        n_ext_len  = r_ext_len;
        n_done     = r_done;
        n_ext_shut = r_ext_shut;
        n_slash    = r_slash;
        n_too_long = r_too_long;
        path_step  = 1'b0;
        ext_step   = 1'b0;
        line_end   = (i_byte == CHR_LF) || (i_byte == CHR_NUL);

        if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + 1'b1;
            if (!r_done) begin
                case (r_phase)
                    PH_WAIT_VERB: begin
                        if (i_byte == CHR_NUL) begin
                            n_done = 1'b1;
                        end else if (i_byte != CHR_LF && i_byte != CHR_SPACE) begin
                            n_phase = PH_IN_VERB;
                        end
                    end
                    PH_IN_VERB: begin
                        if (line_end) begin
                            n_done = 1'b1;
                        end else if (i_byte == CHR_SPACE) begin
                            n_phase = PH_WAIT_PATH;
                        end
                    end
                    PH_WAIT_PATH: begin
                        if (line_end) begin
                            n_done = 1'b1;
                        end else if (i_byte != CHR_SPACE) begin
                            n_phase   = PH_IN_PATH;
                            n_off     = r_pos[OFF_W-1:0];
                            path_step = 1'b1;
                        end
                    end
                    PH_IN_PATH: begin
                        if (line_end || i_byte == CHR_SPACE) begin
                            n_done = 1'b1;
                        end else begin
                            path_step = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT_VERB;
                    end
                endcase

                // verb character: first byte or further bytes of the verb
                if ((r_phase == PH_WAIT_VERB && n_phase == PH_IN_VERB)
                    || (r_phase == PH_IN_VERB && !line_end && i_byte != CHR_SPACE)) begin
                    if (r_vlen >= 3'd3 || i_byte != VERB_GET[r_vlen[1:0]]) begin
                        n_vmatch[0] = 1'b0;
                    end
                    if (r_vlen >= 3'd4 || i_byte != VERB_HEAD[r_vlen[1:0]]) begin
                        n_vmatch[1] = 1'b0;
                    end
                    if (r_vlen < 3'd7) begin
                        n_vlen = r_vlen + 3'd1;
                    end
                end
            end
        end else if (!r_done) begin
            n_too_long = 1'b1;
            n_done     = 1'b1;
        end

        if (path_step) begin
            if (r_pcount == '0) begin
                n_slash = (i_byte == CHR_SLASH);
            end
            if (r_pcount < POS_LIMIT) begin
                n_pcount = r_pcount + 1'b1;
            end
            case (r_dot)
                DS_BEFORE: begin
                    if (i_byte != CHR_DOT) begin
                        n_dot = DS_BASE;
                    end
                end
                DS_BASE: begin
                    if (i_byte == CHR_DOT) begin
                        n_dot = DS_DOTS;
                    end
                end
                DS_DOTS: begin
                    if (i_byte != CHR_DOT) begin
                        n_dot    = DS_EXT;
                        ext_step = 1'b1;
                    end
                end
                default: begin
                    if (!r_ext_shut) begin
                        if (i_byte == CHR_DOT) begin
                            n_ext_shut = 1'b1;
                        end else begin
                            ext_step = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (ext_step) begin
            if (r_ext_len < 3'd4) begin
                n_ext[r_ext_len[1:0]] = i_byte;
            end
            if (r_ext_len < 3'd7) begin
                n_ext_len = r_ext_len + 3'd1;
            end
        end
    end

    // result from the state after this byte
    assign w_off_ext = 32'(n_off);
    assign w_cnt_ext = 32'(n_pcount);

    always_comb begin
        o_result = '0;
        if (n_vmatch[0] && n_vlen == 3'd3) begin
            o_result.method = METHOD_GET;
        end else if (n_vmatch[1] && n_vlen == 3'd4) begin
            o_result.method = METHOD_HEAD;
        end else begin
            o_result.method = METHOD_OTHER;
        end
        o_result.header_too_long = n_too_long;
        if (n_phase == PH_IN_PATH) begin
            o_result.path_found   = 1'b1;
            o_result.path_is_root = (n_pcount == POS_W'(1)) && n_slash;
            if (o_result.path_is_root) begin
                o_result.ext_found  = 1'b1;
                o_result.media_kind = CT_HTML;
            end else if (n_dot == DS_EXT) begin
                o_result.ext_found  = 1'b1;
                o_result.media_kind = match_ext(n_ext, n_ext_len);
            end
            o_result.path_start  = (w_off_ext > 32'(START_MAX)) ? START_MAX
                                                                : w_off_ext[START_W-1:0];
            o_result.path_length = (w_cnt_ext > 32'(LEN_MAX)) ? LEN_MAX
                                                              : w_cnt_ext[LEN_W-1:0];
        end
    end

    // state registers: back to reset values after the final header byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos      <= '0;
            r_phase    <= PH_WAIT_VERB;
            r_vmatch   <= 2'b11;
            r_vlen     <= '0;
            r_off      <= '0;
            r_pcount   <= '0;
            r_dot      <= DS_BEFORE;
            r_ext      <= '0;
            r_ext_len  <= '0;
            r_done     <= 1'b0;
            r_ext_shut <= 1'b0;
            r_slash    <= 1'b0;
            r_too_long <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_vmatch   <= n_vmatch;
            r_vlen     <= n_vlen;
            r_off      <= n_off;
            r_pcount   <= n_pcount;
            r_dot      <= n_dot;
            r_ext      <= n_ext;
            r_ext_len  <= n_ext_len;
            r_done     <= n_done;
            r_ext_shut <= n_ext_shut;
            r_slash    <= n_slash;
            r_too_long <= n_too_long;
        end
    end

endmodule

// File: sv/http_request_line_classifier.sv
// ----------------------------------------------------------------------------
// http_request_line_classifier
// Parses the first line of an HTTP request header, one byte per transaction,
// and returns one classification on the byte marked as the last of a header.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_ready  | o_method .. o_header_too_long
//
//  One byte per cycle sustained; a result is registered: its last byte goes into
//  the input register on acceptance, then its result into the result register.
//  Reset is synchronous and active low; it clears all parse state at once.
//  Bytes without the last flag keep flowing while a result waits; a last byte
//  is held in the input register until the result register is free.
// ----------------------------------------------------------------------------
module http_request_line_classifier #(
    parameter int HEADER_BYTES = hrlc_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hrlc_pkg::METHOD_W-1:0] o_method,
    output logic                          o_path_found,
    output logic                          o_path_is_root,
    output logic                          o_ext_found,
    output logic [hrlc_pkg::CTYPE_W-1:0]  o_media_kind,
    output logic [hrlc_pkg::START_W-1:0]  o_path_start,
    output logic [hrlc_pkg::LEN_W-1:0]    o_path_length,
    output logic                          o_header_too_long
);
    import hrlc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_advance;

    // a last byte moves on only when the result register can take it
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    hrlc_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_method          = r_out.method;
    assign o_path_found      = r_out.path_found;
    assign o_path_is_root    = r_out.path_is_root;
    assign o_ext_found       = r_out.ext_found;
    assign o_media_kind      = r_out.media_kind;
    assign o_path_start      = r_out.path_start;
    assign o_path_length     = r_out.path_length;
    assign o_header_too_long = r_out.header_too_long;

    // a finished header always reaches the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> o_out_valid)
        else $error("result not loaded after last byte");

    // a waiting result is never overwritten by a following last byte
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !(w_advance && r_in_last))
        else $error("pending result overwritten");

    a_root_is_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_path_is_root) |->
            (o_ext_found && o_media_kind == CT_HTML && o_path_length == LEN_W'(1)))
        else $error("root path result inconsistent");

    a_no_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_path_found) |->
            (!o_path_is_root && !o_ext_found && o_path_length == '0
             && o_path_start == '0))
        else $error("path fields set without a path");

endmodule

// File: verif/hrlc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_result_checker
// Watches both channels of the request-line classifier. It keeps its own copy
// of the parse state, works out the classification of every header from the
// accepted bytes and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module hrlc_result_checker #(
    parameter int HEADER_BYTES = hrlc_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [hrlc_pkg::METHOD_W-1:0] i_method,
    input  logic                          i_path_found,
    input  logic                          i_path_is_root,
    input  logic                          i_ext_found,
    input  logic [hrlc_pkg::CTYPE_W-1:0]  i_media_kind,
    input  logic [hrlc_pkg::START_W-1:0]  i_path_start,
    input  logic [hrlc_pkg::LEN_W-1:0]    i_path_length,
    input  logic                          i_header_too_long,
    output int                            o_mismatches,
    output int                            o_pending
);
    import hrlc_pkg::*;

    // parse state of the header in flight
    logic [16:0] byte_pos;
    t_phase      phase;
    logic [1:0]  verb_live;   // bit 0 GET still possible, bit 1 HEAD
    logic [2:0]  verb_len;
    logic [16:0] path_off;
    logic [16:0] path_len;
    t_dot        dot_state;
    t_word4      ext_text;
    logic [2:0]  ext_len;
    logic        line_closed;
    logic        ext_closed;
    logic        slash_first;
    logic        overlong;

    t_result     expected_results[$];
    int          mismatches;

    function automatic void clear_parse();
        byte_pos    = '0;
        phase       = PH_WAIT_VERB;
        verb_live   = 2'b11;
        verb_len    = '0;
        path_off    = '0;
        path_len    = '0;
        dot_state   = DS_BEFORE;
        ext_text    = '0;
        ext_len     = '0;
        line_closed = 1'b0;
        ext_closed  = 1'b0;
        slash_first = 1'b0;
        overlong    = 1'b0;
    endfunction

    function automatic void take_verb(input logic [7:0] c);
        if (verb_len >= 3'd3 || c != VERB_GET[verb_len[1:0]]) verb_live[0] = 1'b0;
        if (verb_len >= 3'd4 || c != VERB_HEAD[verb_len[1:0]]) verb_live[1] = 1'b0;
        if (verb_len < 3'd7) verb_len = verb_len + 3'd1;
    endfunction

    function automatic void keep_ext(input logic [7:0] c);
        if (ext_len < 3'd4) ext_text[ext_len[1:0]] = c;
        if (ext_len < 3'd7) ext_len = ext_len + 3'd1;
    endfunction

    function automatic void take_path(input logic [7:0] c);
        if (path_len == 0) slash_first = (c == CHR_SLASH);
        if (path_len < HEADER_BYTES) path_len = path_len + 17'd1;
        case (dot_state)
            DS_BEFORE: begin
                if (c != CHR_DOT) dot_state = DS_BASE;
            end
            DS_BASE: begin
                if (c == CHR_DOT) dot_state = DS_DOTS;
            end
            DS_DOTS: begin
                if (c != CHR_DOT) begin
                    dot_state = DS_EXT;
                    keep_ext(c);
                end
            end
            default: begin
                // the extension ends at the next dot
                if (!ext_closed) begin
                    if (c == CHR_DOT) ext_closed = 1'b1;
                    else keep_ext(c);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic stop;
        stop = (c == CHR_LF) || (c == CHR_NUL);
        case (phase)
            PH_WAIT_VERB: begin
                if (c == CHR_NUL) begin
                    line_closed = 1'b1;
                end else if (c != CHR_LF && c != CHR_SPACE) begin
                    phase = PH_IN_VERB;
                    take_verb(c);
                end
            end
            PH_IN_VERB: begin
                if (stop) line_closed = 1'b1;
                else if (c == CHR_SPACE) phase = PH_WAIT_PATH;
                else take_verb(c);
            end
            PH_WAIT_PATH: begin
                if (stop) begin
                    line_closed = 1'b1;
                end else if (c != CHR_SPACE) begin
                    phase    = PH_IN_PATH;
                    path_off = byte_pos;
                    take_path(c);
                end
            end
            default: begin
                if (stop || c == CHR_SPACE) line_closed = 1'b1;
                else take_path(c);
            end
        endcase
    endfunction

    // prefix test of the captured extension against one word of n characters
    function automatic logic ext_is(input logic [7:0] c0, c1, c2, c3, input int n);
        t_word4 want;
        logic   ok;
        want = {c3, c2, c1, c0};
        ok   = (int'(ext_len) >= n);
        for (int k = 0; k < 4; k++) begin
            if (k < n && ext_text[k] != want[k]) ok = 1'b0;
        end
        return ok;
    endfunction

    // first hit wins, so jpg is tried before jpeg
    function automatic logic [CTYPE_W-1:0] ext_class();
        if (ext_is("h", "t", "m", "l", 4)) return CT_HTML;
        if (ext_is("j", "s", 8'h00, 8'h00, 2)) return CT_JS;
        if (ext_is("c", "s", "s", 8'h00, 3)) return CT_CSS;
        if (ext_is("p", "n", "g", 8'h00, 3)) return CT_PNG;
        if (ext_is("j", "p", "g", 8'h00, 3)) return CT_JPEG;
        if (ext_is("j", "p", "e", "g", 4)) return CT_JPEG;
        if (ext_is("t", "x", "t", 8'h00, 3)) return CT_PLAIN;
        if (ext_is("m", "d", 8'h00, 8'h00, 2)) return CT_PLAIN;
        if (ext_is("p", "d", "f", 8'h00, 3)) return CT_PDF;
        return CT_HTML;
    endfunction

    function automatic t_result classify_header();
        t_result r;
        r = '0;
        if (verb_live[0] && verb_len == 3'd3) r.method = METHOD_GET;
        else if (verb_live[1] && verb_len == 3'd4) r.method = METHOD_HEAD;
        else r.method = METHOD_OTHER;
        if (phase == PH_IN_PATH) begin
            r.path_found   = 1'b1;
            r.path_is_root = (path_len == 17'd1) && slash_first;
            if (r.path_is_root) begin
                r.ext_found  = 1'b1;
                r.media_kind = CT_HTML;
            end else if (dot_state == DS_EXT) begin
                r.ext_found  = 1'b1;
                r.media_kind = ext_class();
            end
            r.path_start  = (path_off > START_MAX) ? START_MAX : path_off[START_W-1:0];
            r.path_length = (path_len > LEN_MAX) ? LEN_MAX : path_len[LEN_W-1:0];
        end
        r.header_too_long = overlong;
        return r;
    endfunction

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                // bytes past the header limit are dropped
                if (byte_pos < HEADER_BYTES) begin
                    if (!line_closed) scan_byte(i_data_byte);
                    byte_pos = byte_pos + 17'd1;
                end else if (!line_closed) begin
                    overlong    = 1'b1;
                    line_closed = 1'b1;
                end
                if (i_last_byte) begin
                    expected_results.push_back(classify_header());
                    clear_parse();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no header pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    mismatches += field_bad("method", want.method, i_method);
                    mismatches += field_bad("path_found", want.path_found, i_path_found);
                    mismatches += field_bad("path_is_root", want.path_is_root, i_path_is_root);
                    mismatches += field_bad("ext_found", want.ext_found, i_ext_found);
                    mismatches += field_bad("media_kind", want.media_kind, i_media_kind);
                    mismatches += field_bad("path_start", want.path_start, i_path_start);
                    mismatches += field_bad("path_length", want.path_length, i_path_length);
                    mismatches += field_bad("header_too_long", want.header_too_long,
                                            i_header_too_long);
                end
            end
        end
        o_pending    = expected_results.size();
        o_mismatches = mismatches;
    end

endmodule

// File: verif/tb_http_request_line_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_line_classifier
// Feeds request headers to the classifier one byte per transaction: a short
// directed set, then random well-formed, truncated and garbage headers, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_http_request_line_classifier;
    import hrlc_pkg::*;

    localparam int HDR_LIMIT      = HEADER_BYTES_DEFAULT;
    localparam int RANDOM_BYTES   = 900;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_data_byte;
    logic                i_last_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [METHOD_W-1:0] o_method;
    logic                o_path_found;
    logic                o_path_is_root;
    logic                o_ext_found;
    logic [CTYPE_W-1:0]  o_media_kind;
    logic [START_W-1:0]  o_path_start;
    logic [LEN_W-1:0]    o_path_length;
    logic                o_header_too_long;

    int                  mismatches;
    int                  pending;
    logic                calm;
    int                  idle_cycles;
    logic [7:0]          req_bytes[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    http_request_line_classifier #(
        .HEADER_BYTES(HDR_LIMIT)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_method         (o_method),
        .o_path_found     (o_path_found),
        .o_path_is_root   (o_path_is_root),
        .o_ext_found      (o_ext_found),
        .o_media_kind     (o_media_kind),
        .o_path_start     (o_path_start),
        .o_path_length    (o_path_length),
        .o_header_too_long(o_header_too_long)
    );

    hrlc_result_checker #(
        .HEADER_BYTES(HDR_LIMIT)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_method         (o_method),
        .i_path_found     (o_path_found),
        .i_path_is_root   (o_path_is_root),
        .i_ext_found      (o_ext_found),
        .i_media_kind     (o_media_kind),
        .i_path_start     (o_path_start),
        .i_path_length    (o_path_length),
        .i_header_too_long(o_header_too_long),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // mostly back to back, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endfunction

    function automatic void put_rep(input logic [7:0] c, input int n);
        repeat (n) req_bytes.push_back(c);
    endfunction

    function automatic logic [7:0] path_char();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return 8'h0D;
        if (r == 1) return 8'($urandom_range(128, 255));
        if (r < 4) return CHR_SLASH;
        if (r < 8) return 8'($urandom_range(48, 57));
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic string ext_word();
        case ($urandom_range(0, 19))
            0: return "html";
            1: return "htm";
            2: return "htmlx";
            3: return "js";
            4: return "json";
            5: return "j";
            6: return "css";
            7: return "cs";
            8: return "png";
            9: return "jpg";
            10: return "jpeg";
            11: return "jpe";
            12: return "jp";
            13: return "txt";
            14: return "md";
            15: return "m";
            16: return "pdf";
            17: return "PDF";
            18: return "gif";
            default: return "";
        endcase
    endfunction

    function automatic void put_verb();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: put_str("GET");
            4, 5, 6: put_str("HEAD");
            7: put_str("POST");
            8: put_str("GE");
            9: put_str("HEA");
            10: put_str("GETS");
            11: put_str("HEADX");
            12: put_str("get");
            13: put_str("G");
            default: begin
                repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom_range(65, 90)));
            end
        endcase
    endfunction

    function automatic void put_path();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            put_str("/");
            return;
        end
        if ($urandom_range(0, 15) == 0) put_rep(CHR_DOT, $urandom_range(1, 2));
        if ($urandom_range(0, 4) != 0) req_bytes.push_back(CHR_SLASH);
        n = $urandom_range(0, 8);
        repeat (n) req_bytes.push_back(path_char());
        if ($urandom_range(0, 4) != 0) begin
            put_rep(CHR_DOT, ($urandom_range(0, 3) == 0) ? 2 : 1);
            put_str(ext_word());
            if ($urandom_range(0, 4) == 0) begin
                put_rep(CHR_DOT, 1);
                n = $urandom_range(0, 4);
                repeat (n) req_bytes.push_back(path_char());
            end
        end
    endfunction

    function automatic void put_ending();
        case ($urandom_range(0, 5))
            0, 1: put_str(" HTTP/1.1\015\012Host: a\015\012\015\012");
            2: req_bytes.push_back(CHR_LF);
            3: req_bytes.push_back(CHR_NUL);
            4: ;
            default: req_bytes.push_back(CHR_SPACE);
        endcase
        repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_request();
        int r;
        req_bytes.delete();
        repeat ($urandom_range(0, 3)) req_bytes.push_back($urandom_range(0, 1) ? CHR_LF : CHR_SPACE);
        put_verb();
        r = $urandom_range(0, 9);
        if (r != 0) begin
            put_rep(CHR_SPACE, $urandom_range(1, 3));
            if (r != 1) put_path();
        end
        put_ending();
        // cut some headers short anywhere
        if ($urandom_range(0, 6) == 0) begin
            r = $urandom_range(1, req_bytes.size());
            while (req_bytes.size() > r) void'(req_bytes.pop_back());
        end
    endfunction

    function automatic void build_noise();
        req_bytes.delete();
        repeat ($urandom_range(1, 24)) req_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++) begin
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        req_bytes.delete();
        put_str(s);
        send_request();
    endtask

    // hold the sender until every result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : sink
        int n;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = $urandom_range(1, 16);
            repeat (n) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
            if (!calm) begin
                n = pick_gap();
                repeat (n) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("http_request_line_classifier verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int sent;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        calm        <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-byte headers: zero byte, then a top byte as a bare verb
        req_bytes.delete();
        req_bytes.push_back(CHR_NUL);
        send_request();
        req_bytes.delete();
        req_bytes.push_back(8'hFF);
        send_request();

        send_text("GET /\012");
        send_text("HEAD /a.css x");
        send_text("\012 \012GET   /img.jpeg\015 HTTP");
        send_text("GET");
        send_text("HEAD  /dir/name.");
        send_text("POST ..a.b.pdf.x");
        send_text("GET /x..md.gz\012");
        send_text("GET /v.js ");
        send_text("GET /p.png\012");
        send_text("GET /q.jpg");
        send_text("GET /t.txt");
        send_text("GET /f.pdf");
        send_text("GET /h.htmlx");
        req_bytes.delete();
        put_str("GET /a");
        req_bytes.push_back(CHR_NUL);
        put_str("b.js");
        send_request();
        wait_drained();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) calm <= !calm;
            if ($urandom_range(0, 6) == 0) build_noise();
            else build_request();
            send_request();
            sent += req_bytes.size();
            if ($urandom_range(0, 24) == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("http_request_line_classifier verification clean");
        end else begin
            $display("http_request_line_classifier verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/hrlc_pkg.sv
sv/hrlc_parser.sv
sv/http_request_line_classifier.sv
verif/hrlc_result_checker.sv
verif/tb_http_request_line_classifier.sv
